FILE: src/fjot_pkg.sv
// fjot_pkg: shared types, character constants and helper functions for the
// flat object tokenizer. No dependencies.

package fjot_pkg;

   // parse mode, 4 bits; codes above MODE_FINISHED are never reached
   typedef enum logic [3:0] {
      MODE_PRE        = 4'd0,
      MODE_KEY_WAIT   = 4'd1,
      MODE_IN_KEY     = 4'd2,
      MODE_KEY_ESC    = 4'd3,
      MODE_COLON_WAIT = 4'd4,
      MODE_VAL_WAIT   = 4'd5,
      MODE_IN_VAL     = 4'd6,
      MODE_VAL_ESC    = 4'd7,
      MODE_SCALAR     = 4'd8,
      MODE_SEP_WAIT   = 4'd9,
      MODE_FINISHED   = 4'd10
   } mode_type;

   typedef enum logic [2:0] {
      KIND_KEY_CHAR = 3'd0,
      KIND_VAL_CHAR = 3'd1,
      KIND_KEY_END  = 3'd2,
      KIND_VAL_END  = 3'd3,
      KIND_DONE     = 3'd4,
      KIND_ERROR    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NOT_OBJECT   = 3'd0,
      ERR_NO_KEY_QUOTE = 3'd1,
      ERR_ESC_AT_END   = 3'd2,
      ERR_UNTERMINATED = 3'd3,
      ERR_NO_COLON     = 3'd4,
      ERR_NO_SEP       = 3'd5
   } err_type;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // most results one input item can cause
   localparam int unsigned MaxResults = 2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      err_type    error_code;
      logic       last_of_run;
   } rsp_type;

   // results of one accepted item, slot 0 first
   typedef struct packed {
      logic [1:0]  count;
      rsp_type [MaxResults-1:0] item;
   } step_type;

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [7:0] unescape(logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h62:   r = CH_BS;   // b
         8'h66:   r = CH_FF;   // f
         8'h6E:   r = CH_LF;   // n
         8'h72:   r = CH_CR;   // r
         8'h74:   r = CH_TAB;  // t
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic rsp_type mk_rsp(kind_type k, logic [7:0] b, err_type e);
      rsp_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.error_code  = e;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

FILE: src/flat_json_object_tokenizer_top.sv
// flat_json_object_tokenizer_top: top level of the flat object tokenizer.
// Depends on fjot_pkg, fjot_parse and fjot_rsp_fifo.
//
// The tokenizer takes one body item per req transfer and returns a stream of
// rsp transfers: key and value characters (escapes decoded), key end, value
// end, and exactly one object done or error per body. Each request causes
// zero, one or two results; the last result of a request carries last_of_run.
// A request is decoded in the cycle it is taken and its results are written
// into a four-entry result queue, so a new request can be taken every cycle
// while the queue has room for two results. Throughput is one request per
// cycle as long as the result side keeps up, since the result port drains one
// result per cycle; a request that makes two results (such as value end and
// done on a closing brace) puts one more result through the port. Results are
// registered in the queue and can show on rsp_valid from the cycle after the
// request transfer. After reset the block starts in the "before opening brace"
// mode and returns there after every request with last set.

module flat_json_object_tokenizer_top import fjot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   step_type step;
   logic     take;

   // request transfer
   assign take = req_valid && req_ready;

   // mode register and per-byte decode
   fjot_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .step     (step)
   );

   // result queue; space also gates the request side
   fjot_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .step      (step),
      .space     (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/fjot_parse.sv
// fjot_parse: parse mode register and the per-byte transition logic that
// turns one input item into up to two results. Depends on fjot_pkg.

module fjot_parse import fjot_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  req_data,
   output step_type step
);

   mode_type mode_ff, mode_in;
   mode_type m;
   logic [1:0] cnt;
   rsp_type [MaxResults-1:0] res;
   logic [7:0] c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PRE;
      end else if (take) begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      c   = req_data.in_byte;
      m   = mode_ff;
      cnt = 2'd0;
      res[0] = mk_rsp(KIND_DONE, 8'd0, ERR_NOT_OBJECT);
      res[1] = mk_rsp(KIND_DONE, 8'd0, ERR_NOT_OBJECT);

      // byte handling: at most two results (value end then done)
      if (req_data.has_byte) begin
         case (mode_ff)
            MODE_PRE: begin
               if (!is_blank(c)) begin
                  if (c == CH_LBRACE) begin
                     m = MODE_KEY_WAIT;
                  end else begin
                     res[0] = mk_rsp(KIND_ERROR, 8'd0, ERR_NOT_OBJECT);
                     cnt = 2'd1;
                     m = MODE_FINISHED;
                  end
               end
            end
            MODE_KEY_WAIT: begin
               if (!is_blank(c)) begin
                  if (c == CH_RBRACE) begin
                     res[0] = mk_rsp(KIND_DONE, 8'd0, ERR_NOT_OBJECT);
                     cnt = 2'd1;
                     m = MODE_FINISHED;
                  end else if (c == CH_QUOTE) begin
                     m = MODE_IN_KEY;
                  end else begin
                     res[0] = mk_rsp(KIND_ERROR, 8'd0, ERR_NO_KEY_QUOTE);
                     cnt = 2'd1;
                     m = MODE_FINISHED;
                  end
               end
            end
            MODE_IN_KEY: begin
               if (c == CH_QUOTE) begin
                  res[0] = mk_rsp(KIND_KEY_END, 8'd0, ERR_NOT_OBJECT);
                  cnt = 2'd1;
                  m = MODE_COLON_WAIT;
               end else if (c == CH_BSLASH) begin
                  m = MODE_KEY_ESC;
               end else begin
                  res[0] = mk_rsp(KIND_KEY_CHAR, c, ERR_NOT_OBJECT);
                  cnt = 2'd1;
               end
            end
            MODE_KEY_ESC: begin
               res[0] = mk_rsp(KIND_KEY_CHAR, unescape(c), ERR_NOT_OBJECT);
               cnt = 2'd1;
               m = MODE_IN_KEY;
            end
            MODE_COLON_WAIT: begin
               if (!is_blank(c)) begin
                  if (c == CH_COLON) begin
                     m = MODE_VAL_WAIT;
                  end else begin
                     res[0] = mk_rsp(KIND_ERROR, 8'd0, ERR_NO_COLON);
                     cnt = 2'd1;
                     m = MODE_FINISHED;
                  end
               end
            end
            MODE_VAL_WAIT, MODE_SCALAR: begin
               if (mode_ff == MODE_VAL_WAIT && c == CH_QUOTE) begin
                  m = MODE_IN_VAL;
               end else if (c == CH_COMMA) begin
                  res[0] = mk_rsp(KIND_VAL_END, 8'd0, ERR_NOT_OBJECT);
                  cnt = 2'd1;
                  m = MODE_KEY_WAIT;
               end else if (c == CH_RBRACE) begin
                  res[0] = mk_rsp(KIND_VAL_END, 8'd0, ERR_NOT_OBJECT);
                  res[1] = mk_rsp(KIND_DONE, 8'd0, ERR_NOT_OBJECT);
                  cnt = 2'd2;
                  m = MODE_FINISHED;
               end else if (is_blank(c)) begin
                  // blank before a value is skipped, after a scalar it ends it
                  if (mode_ff == MODE_SCALAR) begin
                     res[0] = mk_rsp(KIND_VAL_END, 8'd0, ERR_NOT_OBJECT);
                     cnt = 2'd1;
                     m = MODE_SEP_WAIT;
                  end
               end else begin
                  res[0] = mk_rsp(KIND_VAL_CHAR, c, ERR_NOT_OBJECT);
                  cnt = 2'd1;
                  m = MODE_SCALAR;
               end
            end
            MODE_IN_VAL: begin
               if (c == CH_QUOTE) begin
                  res[0] = mk_rsp(KIND_VAL_END, 8'd0, ERR_NOT_OBJECT);
                  cnt = 2'd1;
                  m = MODE_SEP_WAIT;
               end else if (c == CH_BSLASH) begin
                  m = MODE_VAL_ESC;
               end else begin
                  res[0] = mk_rsp(KIND_VAL_CHAR, c, ERR_NOT_OBJECT);
                  cnt = 2'd1;
               end
            end
            MODE_VAL_ESC: begin
               res[0] = mk_rsp(KIND_VAL_CHAR, unescape(c), ERR_NOT_OBJECT);
               cnt = 2'd1;
               m = MODE_IN_VAL;
            end
            MODE_SEP_WAIT: begin
               if (!is_blank(c)) begin
                  if (c == CH_COMMA) begin
                     m = MODE_KEY_WAIT;
                  end else if (c == CH_RBRACE) begin
                     res[0] = mk_rsp(KIND_DONE, 8'd0, ERR_NOT_OBJECT);
                     cnt = 2'd1;
                     m = MODE_FINISHED;
                  end else begin
                     res[0] = mk_rsp(KIND_ERROR, 8'd0, ERR_NO_SEP);
                     cnt = 2'd1;
                     m = MODE_FINISHED;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // end of body; a done or error from the byte left m finished
      if (req_data.last) begin
         case (m)
            MODE_PRE: begin
               res[cnt[0]] = mk_rsp(KIND_DONE, 8'd0, ERR_NOT_OBJECT);
               cnt = cnt + 2'd1;
            end
            MODE_KEY_WAIT: begin
               res[cnt[0]] = mk_rsp(KIND_ERROR, 8'd0, ERR_NO_KEY_QUOTE);
               cnt = cnt + 2'd1;
            end
            MODE_IN_KEY, MODE_IN_VAL: begin
               res[cnt[0]] = mk_rsp(KIND_ERROR, 8'd0, ERR_UNTERMINATED);
               cnt = cnt + 2'd1;
            end
            MODE_KEY_ESC, MODE_VAL_ESC: begin
               res[cnt[0]] = mk_rsp(KIND_ERROR, 8'd0, ERR_ESC_AT_END);
               cnt = cnt + 2'd1;
            end
            MODE_COLON_WAIT: begin
               res[cnt[0]] = mk_rsp(KIND_ERROR, 8'd0, ERR_NO_COLON);
               cnt = cnt + 2'd1;
            end
            MODE_VAL_WAIT, MODE_SCALAR, MODE_SEP_WAIT: begin
               res[cnt[0]] = mk_rsp(KIND_ERROR, 8'd0, ERR_NO_SEP);
               cnt = cnt + 2'd1;
            end
            default: begin
            end
         endcase
         m = MODE_PRE;
      end

      if (cnt == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end else if (cnt == 2'd1) begin
         res[0].last_of_run = 1'b1;
      end

      mode_in    = m;
      step.count = cnt;
      step.item  = res;
   end

endmodule

FILE: src/fjot_rsp_fifo.sv
// fjot_rsp_fifo: four-entry result queue that takes up to two results per
// cycle and hands out one per cycle unless stalled. Depends on fjot_pkg.

module fjot_rsp_fifo import fjot_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  step_type step,
   output logic     space,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int unsigned Depth = 4;

   rsp_type    mem_ff [Depth];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] n_push;
   logic       pop;

   assign n_push    = push ? step.count : 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // room for a full run of results
   assign space     = (count_ff <= 3'(Depth - MaxResults));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, n_push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step.item[0];
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= step.item[1];
      end
   end

endmodule

FILE: src/fjot_checker.sv
// fjot_checker: port-level checks for the tokenizer top, bound onto it.
// Depends on fjot_pkg and flat_json_object_tokenizer_top.

module fjot_checker import fjot_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // only character results carry a byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_KEY_CHAR && rsp_data.kind != KIND_VAL_CHAR
      |-> rsp_data.out_byte == 8'd0)
      else $error("byte on non-character result");

   // error code only on error results
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_ERROR |-> rsp_data.error_code == ERR_NOT_OBJECT)
      else $error("error code on non-error result");

   // done and error always close the run of their request
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_DONE || rsp_data.kind == KIND_ERROR)
      |-> rsp_data.last_of_run)
      else $error("body end not last of run");

   // results appear only after some request was taken
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without request");

endmodule

bind flat_json_object_tokenizer_top fjot_checker u_fjot_checker (.*);

FILE: tb/token_stream_check.sv
// token_stream_check: watches both channels of the flat object tokenizer,
// predicts the token stream of every accepted request and compares results.
// Depends on fjot_pkg for the payload types, enums and character codes.

module token_stream_check import fjot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count,
   output int      done_count,
   output int      error_count
);

   localparam logic [7:0] ESC_B = 8'h62;
   localparam logic [7:0] ESC_F = 8'h66;
   localparam logic [7:0] ESC_N = 8'h6E;
   localparam logic [7:0] ESC_R = 8'h72;
   localparam logic [7:0] ESC_T = 8'h74;

   mode_type parse_mode = MODE_PRE;
   rsp_type  expected_tokens[$];
   rsp_type  step_tokens[$];

   function automatic void add_token(kind_type k, logic [7:0] b, err_type e);
      rsp_type t;
      t.kind        = k;
      t.out_byte    = b;
      t.error_code  = e;
      t.last_of_run = 1'b0;
      step_tokens = {step_tokens, t};
   endfunction

   function automatic logic skip_char(logic [7:0] c);
      return c inside {CH_SPACE, [CH_TAB:CH_CR]};
   endfunction

   function automatic logic [7:0] escaped_char(logic [7:0] c);
      case (c)
         ESC_B:   return CH_BS;
         ESC_F:   return CH_FF;
         ESC_N:   return CH_LF;
         ESC_R:   return CH_CR;
         ESC_T:   return CH_TAB;
         default: return c;
      endcase
   endfunction

   // tokens of one request go to step_tokens; returns the mode that follows
   function automatic mode_type advance_mode(mode_type m, req_type r);
      mode_type   nxt = m;
      logic [7:0] c   = r.in_byte;
      if (r.has_byte) begin
         case (m)
            MODE_PRE: begin
               if (!skip_char(c)) begin
                  if (c == CH_LBRACE) begin
                     nxt = MODE_KEY_WAIT;
                  end else begin
                     add_token(KIND_ERROR, 8'h00, ERR_NOT_OBJECT);
                     nxt = MODE_FINISHED;
                  end
               end
            end
            MODE_KEY_WAIT: begin
               if (!skip_char(c)) begin
                  if (c == CH_RBRACE) begin
                     add_token(KIND_DONE, 8'h00, ERR_NOT_OBJECT);
                     nxt = MODE_FINISHED;
                  end else if (c == CH_QUOTE) begin
                     nxt = MODE_IN_KEY;
                  end else begin
                     add_token(KIND_ERROR, 8'h00, ERR_NO_KEY_QUOTE);
                     nxt = MODE_FINISHED;
                  end
               end
            end
            MODE_IN_KEY: begin
               if (c == CH_QUOTE) begin
                  add_token(KIND_KEY_END, 8'h00, ERR_NOT_OBJECT);
                  nxt = MODE_COLON_WAIT;
               end else if (c == CH_BSLASH) begin
                  nxt = MODE_KEY_ESC;
               end else begin
                  add_token(KIND_KEY_CHAR, c, ERR_NOT_OBJECT);
               end
            end
            MODE_KEY_ESC: begin
               add_token(KIND_KEY_CHAR, escaped_char(c), ERR_NOT_OBJECT);
               nxt = MODE_IN_KEY;
            end
            MODE_COLON_WAIT: begin
               if (!skip_char(c)) begin
                  if (c == CH_COLON) begin
                     nxt = MODE_VAL_WAIT;
                  end else begin
                     add_token(KIND_ERROR, 8'h00, ERR_NO_COLON);
                     nxt = MODE_FINISHED;
                  end
               end
            end
            MODE_VAL_WAIT: begin
               if (!skip_char(c)) begin
                  if (c == CH_QUOTE) begin
                     nxt = MODE_IN_VAL;
                  end else if (c == CH_COMMA) begin
                     add_token(KIND_VAL_END, 8'h00, ERR_NOT_OBJECT);
                     nxt = MODE_KEY_WAIT;
                  end else if (c == CH_RBRACE) begin
                     add_token(KIND_VAL_END, 8'h00, ERR_NOT_OBJECT);
                     add_token(KIND_DONE, 8'h00, ERR_NOT_OBJECT);
                     nxt = MODE_FINISHED;
                  end else begin
                     add_token(KIND_VAL_CHAR, c, ERR_NOT_OBJECT);
                     nxt = MODE_SCALAR;
                  end
               end
            end
            MODE_IN_VAL: begin
               if (c == CH_QUOTE) begin
                  add_token(KIND_VAL_END, 8'h00, ERR_NOT_OBJECT);
                  nxt = MODE_SEP_WAIT;
               end else if (c == CH_BSLASH) begin
                  nxt = MODE_VAL_ESC;
               end else begin
                  add_token(KIND_VAL_CHAR, c, ERR_NOT_OBJECT);
               end
            end
            MODE_VAL_ESC: begin
               add_token(KIND_VAL_CHAR, escaped_char(c), ERR_NOT_OBJECT);
               nxt = MODE_IN_VAL;
            end
            MODE_SCALAR: begin
               if (c == CH_COMMA) begin
                  add_token(KIND_VAL_END, 8'h00, ERR_NOT_OBJECT);
                  nxt = MODE_KEY_WAIT;
               end else if (c == CH_RBRACE) begin
                  add_token(KIND_VAL_END, 8'h00, ERR_NOT_OBJECT);
                  add_token(KIND_DONE, 8'h00, ERR_NOT_OBJECT);
                  nxt = MODE_FINISHED;
               end else if (skip_char(c)) begin
                  add_token(KIND_VAL_END, 8'h00, ERR_NOT_OBJECT);
                  nxt = MODE_SEP_WAIT;
               end else begin
                  add_token(KIND_VAL_CHAR, c, ERR_NOT_OBJECT);
               end
            end
            MODE_SEP_WAIT: begin
               if (!skip_char(c)) begin
                  if (c == CH_COMMA) begin
                     nxt = MODE_KEY_WAIT;
                  end else if (c == CH_RBRACE) begin
                     add_token(KIND_DONE, 8'h00, ERR_NOT_OBJECT);
                     nxt = MODE_FINISHED;
                  end else begin
                     add_token(KIND_ERROR, 8'h00, ERR_NO_SEP);
                     nxt = MODE_FINISHED;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (r.last) begin
         case (nxt)
            MODE_PRE:        add_token(KIND_DONE, 8'h00, ERR_NOT_OBJECT);
            MODE_KEY_WAIT:   add_token(KIND_ERROR, 8'h00, ERR_NO_KEY_QUOTE);
            MODE_IN_KEY,
            MODE_IN_VAL:     add_token(KIND_ERROR, 8'h00, ERR_UNTERMINATED);
            MODE_KEY_ESC,
            MODE_VAL_ESC:    add_token(KIND_ERROR, 8'h00, ERR_ESC_AT_END);
            MODE_COLON_WAIT: add_token(KIND_ERROR, 8'h00, ERR_NO_COLON);
            MODE_VAL_WAIT,
            MODE_SCALAR,
            MODE_SEP_WAIT:   add_token(KIND_ERROR, 8'h00, ERR_NO_SEP);
            default: begin
            end
         endcase
         nxt = MODE_PRE;
      end
      return nxt;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         parse_mode = MODE_PRE;
         expected_tokens.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result: kind %0d byte %02h code %0d last %0b",
                           rsp_data.kind, rsp_data.out_byte, rsp_data.error_code,
                           rsp_data.last_of_run);
               end
               fail_count <= fail_count + 1;
            end else begin
               want = expected_tokens.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  if (fail_count < 10) begin
                     $display("result %0d mismatch: expected kind %0d byte %02h code %0d last %0b",
                              checked_count, want.kind, want.out_byte, want.error_code,
                              want.last_of_run);
                     $display("   got kind %0d byte %02h code %0d last %0b",
                              rsp_data.kind, rsp_data.out_byte, rsp_data.error_code,
                              rsp_data.last_of_run);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            step_tokens.delete();
            parse_mode = advance_mode(parse_mode, req_data);
            if (step_tokens.size() > 0) begin
               step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
            end
            foreach (step_tokens[i]) begin
               expected_tokens = {expected_tokens, step_tokens[i]};
               if (step_tokens[i].kind == KIND_DONE) done_count <= done_count + 1;
               if (step_tokens[i].kind == KIND_ERROR) error_count <= error_count + 1;
            end
         end
         pending_count <= expected_tokens.size();
      end
   end

endmodule

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for flat_json_object_tokenizer_top.
// Depends on fjot_pkg, the tokenizer RTL and token_stream_check.

module tb_top import fjot_pkg::*; ();

   localparam logic [7:0] VT_CHAR    = 8'h0B;
   localparam int         BODY_ITEMS = 1900;
   // no idling on either side once this many items have gone out
   localparam int         CALM_AFTER = 1700;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_ready = 1'b0;
   req_type req_data  = '0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int done_count;
   int error_count;

   // bytes of the body being built, and how many items went out so far
   logic [7:0] body_bytes[$];
   int         items_sent   = 0;
   bit         sender_idles = 1'b0;
   bit         sink_stalls  = 1'b0;
   bit         noise_on     = 1'b0;

   flat_json_object_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   token_stream_check token_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .done_count    (done_count),
      .error_count   (error_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stall bursts while enabled, otherwise always ready
   initial begin
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // one request transfer, with an optional idle burst in front of it
   task automatic push_item(logic [7:0] b, logic has, logic fin);
      req_type r;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      r.in_byte  = b;
      r.has_byte = has;
      r.last     = fin;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // sends body_bytes; last rides on the final byte or on a bare end marker.
   // only the first 'keep' bytes count, trailing junk after the brace does not
   task automatic send_body(int keep, bit bare_end);
      int n;
      n = body_bytes.size();
      if (n == 0) bare_end = 1'b1;
      for (int i = 0; i < n; i++) begin
         // an item with neither byte nor last is dropped by the block
         if (noise_on && $urandom_range(0, 39) == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         push_item(body_bytes[i], 1'b1, !bare_end && i == n - 1);
         if (i < keep) items_sent++;
      end
      if (bare_end) begin
         push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   // hold the sender until every predicted result has come out
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic void append_byte(logic [7:0] c);
      body_bytes = {body_bytes, c};
   endfunction

   function automatic void load_text(string s);
      body_bytes.delete();
      foreach (s[i]) append_byte(s[i]);
   endfunction

   function automatic void add_blanks(int most);
      repeat ($urandom_range(0, most)) begin
         case ($urandom_range(0, 5))
            0:       append_byte(CH_SPACE);
            1:       append_byte(CH_TAB);
            2:       append_byte(CH_LF);
            3:       append_byte(VT_CHAR);
            4:       append_byte(CH_FF);
            default: append_byte(CH_CR);
         endcase
      end
   endfunction

   // quoted content: any byte, plus backslash escapes of every sort
   function automatic void add_text_chars(int n);
      logic [7:0] c;
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) begin
            append_byte(CH_BSLASH);
            case ($urandom_range(0, 7))
               0:       c = "b";
               1:       c = "f";
               2:       c = "n";
               3:       c = "r";
               4:       c = "t";
               5:       c = CH_QUOTE;
               6:       c = CH_BSLASH;
               default: c = 8'($urandom_range(0, 255));
            endcase
         end else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
         end
         append_byte(c);
      end
   endfunction

   // bare scalar; n of zero leaves an empty value
   function automatic void add_scalar(int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         do c = 8'($urandom_range(0, 255));
         while (c inside {CH_COMMA, CH_RBRACE, CH_SPACE, [CH_TAB:CH_CR]} ||
                (i == 0 && c == CH_QUOTE));
         append_byte(c);
      end
   endfunction

   // well-formed object with random keys, values and spacing
   function automatic void build_object();
      int pairs;
      body_bytes.delete();
      add_blanks(2);
      append_byte(CH_LBRACE);
      pairs = $urandom_range(0, 3);
      for (int k = 0; k < pairs; k++) begin
         add_blanks(2);
         append_byte(CH_QUOTE);
         add_text_chars($urandom_range(0, 5));
         append_byte(CH_QUOTE);
         add_blanks(1);
         append_byte(CH_COLON);
         add_blanks(1);
         if ($urandom_range(0, 1) == 0) begin
            append_byte(CH_QUOTE);
            add_text_chars($urandom_range(0, 6));
            append_byte(CH_QUOTE);
         end else begin
            add_scalar($urandom_range(0, 5));
         end
         add_blanks(1);
         // separator between pairs, and now and then a trailing comma
         if (k < pairs - 1 || $urandom_range(0, 3) == 0) append_byte(CH_COMMA);
      end
      add_blanks(2);
      append_byte(CH_RBRACE);
   endfunction

   initial begin
      int keep;
      int pick;
      int cut;
      int spot;
      bit bare_end;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed bodies: every way a body can end, escapes, trailing comma,
      // bytes after the closing brace and a dropped empty item
      sender_idles = 1'b1;
      sink_stalls <= 1'b1;
      load_text("");               send_body(0, 1'b1);  // empty body
      load_text("x");              send_body(1, 1'b0);  // not an object
      load_text("{");              send_body(1, 1'b0);  // key expected at end
      load_text("{\"\\");          send_body(3, 1'b0);  // ends after a backslash
      load_text("{\"");            send_body(2, 1'b1);  // unterminated key
      load_text("{\"\"");          send_body(3, 1'b0);  // colon missing at end
      push_item(8'hFF, 1'b0, 1'b0);
      load_text("{\"\":");         send_body(4, 1'b0);  // value expected at end
      load_text("{\"\\n\":5,}z");  send_body(9, 1'b0);  // junk after the brace
      wait_all_results();

      // random bodies: mostly well-formed objects, the rest broken or junk
      noise_on = 1'b1;
      while (items_sent < BODY_ITEMS) begin
         sender_idles = items_sent < CALM_AFTER && $urandom_range(0, 3) != 0;
         sink_stalls <= items_sent < CALM_AFTER && $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            build_object();
            keep = body_bytes.size();
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
            end
         end else if (pick < 88) begin
            build_object();
            if ($urandom_range(0, 1) == 0) begin
               // cut the body short somewhere
               cut = $urandom_range(0, body_bytes.size() - 1);
               while (body_bytes.size() > cut) void'(body_bytes.pop_back());
            end else begin
               // overwrite one byte, often with a structural character
               spot = $urandom_range(0, body_bytes.size() - 1);
               case ($urandom_range(0, 5))
                  0:       body_bytes[spot] = CH_COMMA;
                  1:       body_bytes[spot] = CH_COLON;
                  2:       body_bytes[spot] = CH_QUOTE;
                  3:       body_bytes[spot] = CH_RBRACE;
                  default: body_bytes[spot] = 8'($urandom_range(0, 255));
               endcase
            end
            keep = body_bytes.size();
         end else if (pick < 96) begin
            body_bytes.delete();
            if ($urandom_range(0, 1) == 0) append_byte(CH_LBRACE);
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
            keep = body_bytes.size();
         end else begin
            body_bytes.delete();
            add_blanks(3);
            keep = body_bytes.size();
         end
         bare_end = $urandom_range(0, 3) == 0;
         send_body(keep, bare_end);
         if (items_sent < CALM_AFTER && $urandom_range(0, 11) == 0) wait_all_results();
      end

      // drain, then keep watching so that any extra result would still show
      wait_all_results();
      repeat (10) @(posedge clock);

      $display("tokenizer run: %0d body items sent, %0d result transfers checked",
               items_sent, checked_count);
      $display("bodies closed: %0d as complete objects, %0d with an error",
               done_count, error_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/fjot_pkg.sv
src/fjot_parse.sv
src/fjot_rsp_fifo.sv
src/flat_json_object_tokenizer_top.sv
src/fjot_checker.sv
tb/token_stream_check.sv
tb/tb_top.sv
